### rtl/scrs_pkg.sv
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared types and constants for the segment cache read splitter.
// ----------------------------------------------------------------------------
`default_nettype none
package scrs_pkg;

  localparam int unsigned CacheSlots   = 8;
  localparam int unsigned SlotBits     = 3;
  localparam int unsigned UseCountBits = 16;
  localparam int unsigned MaxChunks    = 64;
  localparam int unsigned ChunkCntBits = 7;
  localparam int unsigned SegMax       = 1048576;

  // Register indexes
  localparam logic [2:0] RegFileSize     = 3'd0;
  localparam logic [2:0] RegSegmentSize  = 3'd1;
  localparam logic [2:0] RegCacheEntries = 3'd2;
  localparam logic [2:0] RegWriteOnly    = 3'd3;
  localparam logic [2:0] RegHeaderLoaded = 3'd4;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEof      = 3'd1;
  localparam logic [2:0] StWrOnly   = 3'd2;
  localparam logic [2:0] StNoHeader = 3'd3;
  localparam logic [2:0] StRange    = 3'd4;
  localparam logic [2:0] StOrigin   = 3'd5;

  // Seek origins
  localparam logic [1:0] OrgStart   = 2'd0;
  localparam logic [1:0] OrgCurrent = 2'd1;
  localparam logic [1:0] OrgEnd     = 2'd2;
  localparam logic [1:0] OrgBad     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN,
    S_EVAL,
    S_EMIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] segment_number;
    logic [2:0]  cache_slot;
    logic        miss;
    logic [19:0] offset_in_segment;
    logic [20:0] chunk_bytes;
    logic [31:0] position;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

### rtl/segment_cache_read_splitter_top.sv
// ----------------------------------------------------------------------------
// segment_cache_read_splitter_top
// File position keeper, read splitter and LFU segment cache tag store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per transfer (read or seek). m_axis: result items;
//   a read gives one chunk per segment touched (at most 64), the final one
//   with tlast. Seeks and refused reads give one result with tlast.
//   cfg: register writes (index, data), taken only while idle.
// Sequencing:
//   A seek or refused read result is registered and can transfer in the
//   cycle after its request transfer. A read chunk needs restoring division
//   for segment/offset, a read and a compare step per slot walked in the
//   tag memory (tag and use count share one word; 1..8 slots walked), then
//   a read and a write-back of the chosen slot. Each later chunk starts only
//   after the previous result transfers. The divider sets the rate. A new
//   request is taken in the cycle after a single result transfer; after a
//   read's last chunk the block first passes from its output state to idle.
// Reset:
//   Registers go to their defaults, position to 0, and a clearing pass over
//   all 8 slots zeroes the use counts and tags. No request is taken during
//   the pass.
// Stall:
//   The result register holds until m_axis_tready; work waits meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module segment_cache_read_splitter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: operation[0], byte_count[31:1], seek_offset[63:32], seek_origin[65:64]
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status[2:0], segment_number[34:3], cache_slot[37:35], miss[38],
  //        offset_in_segment[58:39], chunk_bytes[79:59], position[111:80]
  output logic [111:0]     m_axis_tdata,
  output logic             m_axis_tlast
);
  import scrs_pkg::*;

  localparam int unsigned MemW = 32 + UseCountBits;

  // configuration
  logic [31:0] file_size_q;
  logic [20:0] seg_size_q;
  logic [3:0]  entries_q;
  logic        wr_only_q, hdr_q;

  state_e state_q, state_d;

  // memory: {use_count, tag}
  logic [MemW-1:0] mem [CacheSlots];
  logic [MemW-1:0] rd_data_q;
  logic [SlotBits-1:0] rd_addr;
  logic            rd_en;
  logic            wr_en;
  logic [SlotBits-1:0] wr_addr;
  logic [MemW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // clearing pass
  logic [SlotBits:0] clr_q;
  logic              clearing;
  assign clearing = !clr_q[SlotBits];

  // work regs
  logic [31:0] pos_q, nbytes_q;
  logic [ChunkCntBits-1:0] k_q;
  logic [20:0] ssz_q;
  logic [31:0] quo_q;
  logic [20:0] rem_q;
  logic [5:0]  dcnt_q;
  logic [SlotBits-1:0] idx_q, lu_q, sel_q;
  logic [UseCountBits-1:0] lu_cnt_q;
  logic        found_q;
  logic [3:0]  n_q;
  result_t     res_q;
  logic        out_v_q;

  logic in_acc;
  assign s_axis_tready = (state_q == S_IDLE) && !clearing && !out_v_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_v_q;

  logic         op;
  logic [30:0]  in_bytes;
  logic [31:0]  in_off;
  logic [1:0]   in_org;
  assign op       = s_axis_tdata[0];
  assign in_bytes = s_axis_tdata[31:1];
  assign in_off   = s_axis_tdata[63:32];
  assign in_org   = s_axis_tdata[65:64];

  // divider step
  logic [21:0] trial;
  assign trial = {rem_q, quo_q[31]} - {1'b0, ssz_q};

  // scan
  logic [31:0] cur_tag;
  logic [UseCountBits-1:0] cur_cnt;
  assign cur_tag = rd_data_q[31:0];
  assign cur_cnt = rd_data_q[MemW-1:32];

  // seek target
  logic signed [33:0] tgt;
  assign tgt = (in_org == OrgStart) ? 34'(signed'(in_off))
             : ($signed({2'b00, file_size_q}) + 34'(signed'(in_off)));

  logic [32:0] rd_end;
  assign rd_end = {1'b0, pos_q} + {2'b0, in_bytes};

  // chunk size
  logic [20:0] room, cbytes;
  assign room   = ssz_q - rem_q;
  assign cbytes = ({11'b0, room} < nbytes_q) ? room : nbytes_q[20:0];
  logic [31:0] nb_rest;
  assign nb_rest = nbytes_q - {11'b0, cbytes};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_acc && !op && !wr_only_q && hdr_q && !(rd_end > {1'b0, file_size_q}
                   && pos_q >= file_size_q)) state_d = S_DIV;
      S_DIV:     if (dcnt_q == 6'd32) state_d = S_SCAN_RD;
      S_SCAN_RD: state_d = S_SCAN;
      S_SCAN:    begin
        if (cur_cnt == '0 || cur_tag == quo_q || {1'b0, idx_q} + 4'd1 >= n_q)
          state_d = S_EVAL;
        else state_d = S_SCAN_RD;
      end
      S_EVAL:    state_d = S_EMIT;
      S_EMIT:    state_d = S_OUT;
      S_OUT:     if (!out_v_q) state_d = (res_q.last) ? S_IDLE : S_DIV;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en = 1'b0; rd_addr = idx_q;
    wr_en = 1'b0; wr_addr = sel_q; wr_data = '0;
    if (clearing) begin
      wr_en = 1'b1; wr_addr = clr_q[SlotBits-1:0];
    end
    case (state_q)
      S_SCAN_RD: rd_en = 1'b1;
      S_EVAL:    begin rd_en = 1'b1; rd_addr = sel_q; end
      S_EMIT:    begin
        wr_en = 1'b1;
        if (found_q && rd_data_q[MemW-1:32] != '0)
          wr_data = {(&rd_data_q[MemW-1:32]) ? rd_data_q[MemW-1:32]
                     : rd_data_q[MemW-1:32] + 1'b1, rd_data_q[31:0]};
        else wr_data = {UseCountBits'(1), quo_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; clr_q <= '0; out_v_q <= 1'b0;
      file_size_q <= '0; seg_size_q <= 21'd4096; entries_q <= 4'd8;
      wr_only_q <= 1'b0; hdr_q <= 1'b0; pos_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegFileSize:     file_size_q <= cfg_data_i;
          RegSegmentSize:  seg_size_q  <= cfg_data_i[20:0];
          RegCacheEntries: entries_q   <= cfg_data_i[3:0];
          RegWriteOnly:    wr_only_q   <= cfg_data_i[0];
          RegHeaderLoaded: hdr_q       <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (in_acc) begin
          res_q <= '0; res_q.last <= 1'b1; res_q.position <= pos_q;
          k_q <= '0;
          ssz_q <= (seg_size_q == '0) ? 21'd1
                 : (seg_size_q > 21'(SegMax)) ? 21'(SegMax) : seg_size_q;
          n_q <= (entries_q == '0) ? 4'd1
               : (entries_q > 4'(CacheSlots)) ? 4'(CacheSlots) : entries_q;
          quo_q <= pos_q; rem_q <= '0; dcnt_q <= '0;
          if (op) begin
            out_v_q <= 1'b1;
            if (wr_only_q) res_q.status <= StWrOnly;
            else if (in_org == OrgBad) res_q.status <= StOrigin;
            else if (in_org != OrgCurrent) begin
              if (tgt < 0 || tgt > $signed({2'b00, file_size_q}))
                res_q.status <= StRange;
              else begin
                pos_q <= tgt[31:0]; res_q.position <= tgt[31:0];
              end
            end
          end else if (wr_only_q) begin
            res_q.status <= StWrOnly; out_v_q <= 1'b1;
          end else if (!hdr_q) begin
            res_q.status <= StNoHeader; out_v_q <= 1'b1;
          end else if (rd_end > {1'b0, file_size_q}) begin
            if (pos_q >= file_size_q) begin
              res_q.status <= StEof; out_v_q <= 1'b1;
            end else nbytes_q <= file_size_q - pos_q;
          end else nbytes_q <= {1'b0, in_bytes};
        end
        S_DIV: begin
          if (dcnt_q != 6'd32) begin
            dcnt_q <= dcnt_q + 1'b1;
            if (!trial[21]) begin
              rem_q <= trial[20:0]; quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= {rem_q[19:0], quo_q[31]}; quo_q <= {quo_q[30:0], 1'b0};
            end
          end else begin
            idx_q <= '0; lu_q <= '0; lu_cnt_q <= '1; found_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cur_cnt < lu_cnt_q || idx_q == '0) begin
            lu_q <= idx_q; lu_cnt_q <= cur_cnt;
          end
          if (cur_cnt == '0 || cur_tag == quo_q) begin
            sel_q <= idx_q; found_q <= 1'b1;
          end else if ({1'b0, idx_q} + 4'd1 >= n_q) begin
            sel_q <= (cur_cnt < lu_cnt_q) ? idx_q : lu_q; found_q <= 1'b0;
          end else idx_q <= idx_q + 1'b1;
        end
        S_EMIT: begin
          res_q.status <= StOk;
          res_q.segment_number <= quo_q;
          res_q.cache_slot <= sel_q;
          res_q.miss <= !(found_q && rd_data_q[MemW-1:32] != '0);
          res_q.offset_in_segment <= rem_q[19:0];
          res_q.chunk_bytes <= cbytes;
          res_q.position <= pos_q + {11'b0, cbytes};
          res_q.last <= (nb_rest == '0)
                        || (k_q + ChunkCntBits'(1) >= ChunkCntBits'(MaxChunks));
          pos_q <= pos_q + {11'b0, cbytes};
          nbytes_q <= nb_rest;
          k_q <= k_q + 1'b1;
          out_v_q <= 1'b1;
        end
        S_OUT: if (!out_v_q) begin
          quo_q <= pos_q; rem_q <= '0; dcnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {res_q.position, res_q.chunk_bytes, res_q.offset_in_segment,
                          res_q.miss, res_q.cache_slot, res_q.segment_number,
                          res_q.status};
endmodule
`default_nettype wire

### rtl/scrs_checker.sv
// ----------------------------------------------------------------------------
// scrs_checker
// Port-level checks for the segment cache read splitter.
// ----------------------------------------------------------------------------
`default_nettype none
module scrs_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata,
  input wire logic         m_axis_tlast
);
  import scrs_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != StOk |-> m_axis_tlast)
    else $error("error result not last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != StOk |-> m_axis_tdata[79:3] == '0)
    else $error("error result carries chunk");
endmodule

bind segment_cache_read_splitter_top scrs_checker u_scrs_checker (.*);
`default_nettype wire

### test/segment_cache_read_splitter_checker.sv
// ----------------------------------------------------------------------------
// segment_cache_read_splitter_checker
// Watches the request, config and result channels of the read splitter,
// tracks position and cache tags itself and compares every result transfer.
// ----------------------------------------------------------------------------
module segment_cache_read_splitter_checker
  import scrs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,
  input  wire logic         cfg_valid_i,
  input  wire logic         cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [111:0] m_axis_tdata,
  input  wire logic         m_axis_tlast,
  output int                fail_count_o,
  output int                pending_o
);

  logic [31:0] file_len;
  logic [20:0] seg_len;
  logic [3:0]  slots_used;
  logic        wr_only;
  logic        hdr_ok;

  logic [31:0] file_pos;
  logic [31:0] tag_mem [CacheSlots];
  logic [UseCountBits-1:0] use_cnt [CacheSlots];

  result_t chunk_q[$];

  assign pending_o = chunk_q.size();

  function automatic result_t simple_result(logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.position = file_pos;
    r.last = 1'b1;
    return r;
  endfunction

  // Finds the slot for a segment; updates tags and use counts.
  task automatic cache_lookup(input logic [31:0] seg, output logic [2:0] slot,
                              output logic miss);
    int n;
    int lu;
    int i;
    n = (slots_used == 0) ? 1 : (slots_used > CacheSlots ? CacheSlots : slots_used);
    lu = 0;
    for (i = 0; i < n; i++) begin
      if (use_cnt[i] < use_cnt[lu]) lu = i;
      if (use_cnt[i] == 0) break;
      if (tag_mem[i] == seg) break;
    end
    if (i >= n) begin
      i = lu;
      use_cnt[i] = '0;
    end
    miss = 1'b0;
    if (use_cnt[i] == 0) begin
      tag_mem[i] = seg;
      miss = 1'b1;
    end
    if (use_cnt[i] != '1) use_cnt[i]++;
    slot = i[2:0];
  endtask

  task automatic predict_request(input logic [71:0] req);
    logic        op;
    logic [31:0] nbytes;
    logic signed [33:0] target;
    logic [1:0]  origin;
    logic [31:0] ssz;
    logic [31:0] seg;
    logic [31:0] off;
    logic [31:0] take;
    logic [2:0]  slot;
    logic        miss;
    result_t     r;
    int          k;
    op = req[0];
    nbytes = {1'b0, req[31:1]};
    origin = req[65:64];
    if (op) begin
      if (wr_only) chunk_q.push_back(simple_result(StWrOnly));
      else if (origin == OrgBad) chunk_q.push_back(simple_result(StOrigin));
      else if (origin == OrgCurrent) chunk_q.push_back(simple_result(StOk));
      else begin
        target = {{2{req[63]}}, req[63:32]};
        if (origin == OrgEnd) target += {2'b00, file_len};
        if (target < 0 || target > $signed({2'b00, file_len})) begin
          chunk_q.push_back(simple_result(StRange));
        end else begin
          file_pos = target[31:0];
          chunk_q.push_back(simple_result(StOk));
        end
      end
      return;
    end
    if (wr_only) begin
      chunk_q.push_back(simple_result(StWrOnly));
      return;
    end
    if (!hdr_ok) begin
      chunk_q.push_back(simple_result(StNoHeader));
      return;
    end
    if ({1'b0, file_pos} + {1'b0, nbytes} > {1'b0, file_len}) begin
      if (file_pos >= file_len) begin
        chunk_q.push_back(simple_result(StEof));
        return;
      end
      nbytes = file_len - file_pos;
    end
    ssz = (seg_len == 0) ? 1 : (seg_len > SegMax ? SegMax : seg_len);
    k = 0;
    forever begin
      seg = file_pos / ssz;
      off = file_pos % ssz;
      cache_lookup(seg, slot, miss);
      take = (nbytes > ssz - off) ? ssz - off : nbytes;
      nbytes -= take;
      file_pos += take;
      r = '0;
      r.status = StOk;
      r.segment_number = seg;
      r.cache_slot = slot;
      r.miss = miss;
      r.offset_in_segment = off[19:0];
      r.chunk_bytes = take[20:0];
      r.position = file_pos;
      r.last = (nbytes == 0 || k + 1 >= MaxChunks);
      chunk_q.push_back(r);
      k++;
      if (r.last) break;
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    result_t e;
    if (chunk_q.size() == 0) begin
      $error("unexpected result transfer: %h", m_axis_tdata);
      fail_count_o++;
      return;
    end
    e = chunk_q.pop_front();
    check_field("status", e.status, m_axis_tdata[2:0]);
    check_field("segment_number", e.segment_number, m_axis_tdata[34:3]);
    check_field("cache_slot", e.cache_slot, m_axis_tdata[37:35]);
    check_field("miss", e.miss, m_axis_tdata[38]);
    check_field("offset_in_segment", e.offset_in_segment, m_axis_tdata[58:39]);
    check_field("chunk_bytes", e.chunk_bytes, m_axis_tdata[79:59]);
    check_field("position", e.position, m_axis_tdata[111:80]);
    check_field("last", e.last, m_axis_tlast);
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len = 0;
      seg_len = 21'd4096;
      slots_used = 4'd8;
      wr_only = 0;
      hdr_ok = 0;
      file_pos = 0;
      for (int i = 0; i < CacheSlots; i++) use_cnt[i] = '0;
      chunk_q.delete();
    end else begin
      // results first: a request taken this edge cannot answer this edge
      if (m_axis_tvalid && m_axis_tready) check_result();
      // a request taken at the same edge as a register write sees the old value
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegFileSize:     file_len = cfg_data_i;
          RegSegmentSize:  seg_len = cfg_data_i[20:0];
          RegCacheEntries: slots_used = cfg_data_i[3:0];
          RegWriteOnly:    wr_only = cfg_data_i[0];
          RegHeaderLoaded: hdr_ok = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### test/tb_segment_cache_read_splitter_top.sv
// ----------------------------------------------------------------------------
// tb_segment_cache_read_splitter_top
// Drives reads, seeks and register writes into the read splitter with random
// gaps and back-pressure; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_segment_cache_read_splitter_top;
  import scrs_pkg::*;

  localparam logic OpRead = 1'b0;
  localparam logic OpSeek = 1'b1;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;

  int fail_count;
  int pending;
  // receiver hold-off request, counted in the sink process
  bit hold_sink = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  segment_cache_read_splitter_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  segment_cache_read_splitter_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sink: random tready, with a long stall on request.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      g = gap_len();
      if (g == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_req(logic op, logic [30:0] nb, logic [31:0] so, logic [1:0] org);
    repeat (gap_len()) @(negedge clk_i);
    s_axis_tdata <= {6'd0, org, so, nb, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits for all results, then for the block to go quiet before config.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(logic [31:0] fs, logic [31:0] ss, logic [31:0] ce,
                       logic wo, logic hl);
    drain();
    write_reg(RegFileSize, fs);
    write_reg(RegSegmentSize, ss);
    write_reg(RegCacheEntries, ce);
    write_reg(RegWriteOnly, wo);
    write_reg(RegHeaderLoaded, hl);
  endtask

  task automatic rand_read();
    logic [30:0] nb;
    logic [31:0] rnd;
    case ($urandom_range(0, 3))
      0: nb = 31'($urandom_range(0, 64));
      1: nb = 31'($urandom_range(0, 20000));
      2: begin
        rnd = $urandom;
        nb = rnd[31:1];
      end
      default: nb = 31'($urandom_range(0, 300));
    endcase
    send_req(OpRead, nb, $urandom, 2'($urandom_range(0, 3)));
  endtask

  task automatic rand_seek(logic [31:0] fs);
    logic [31:0] so;
    logic [31:0] rnd;
    case ($urandom_range(0, 3))
      0: so = $urandom_range(0, fs > 2000 ? 2000 : fs);
      1: so = -$urandom_range(0, 2000);
      2: so = $urandom;
      default: so = fs - $urandom_range(0, 100);
    endcase
    rnd = $urandom;
    send_req(OpSeek, rnd[31:1], so, 2'($urandom_range(0, 3)));
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (12) @(negedge clk_i);

    // Refusals right after reset: no header, out of range, write-only.
    send_req(OpRead, 31'd10, '0, OrgStart);
    send_req(OpSeek, '0, 32'd5, OrgStart);
    write_reg(RegWriteOnly, 32'd1);
    send_req(OpRead, 31'd10, '0, OrgStart);
    send_req(OpSeek, '0, 32'd5, OrgEnd);

    // Directed: small segments and few slots so replacement kicks in.
    setup(32'd1000, 32'd16, 32'd2, 1'b0, 1'b1);
    send_req(OpRead, 31'd0, '0, OrgStart);                    // zero-byte read
    send_req(OpRead, 31'd40, 32'hffff_ffff, OrgBad);          // spans segments
    send_req(OpSeek, '0, 32'd0, OrgStart);
    send_req(OpRead, 31'd20, '0, OrgStart);
    send_req(OpSeek, '0, 32'd500, OrgStart);
    send_req(OpRead, 31'h7fff_ffff, '0, OrgStart);            // clipped, long read
    send_req(OpSeek, '0, 32'h7fff_ffff, OrgStart);            // out of range
    send_req(OpSeek, '0, 32'h8000_0000, OrgEnd);              // negative target
    send_req(OpSeek, '0, 32'd0, OrgEnd);                      // at end of file
    send_req(OpRead, 31'd1, '0, OrgStart);                    // end of data
    send_req(OpSeek, '0, 32'hffff_fff0, OrgEnd);
    send_req(OpSeek, '0, 32'd1, OrgCurrent);
    send_req(OpSeek, '0, 32'd1, OrgBad);
    send_req(OpRead, 31'd0, '0, OrgStart);

    // Sender pauses until every result is in.
    drain();

    // Odd register values: segment 0, slots 0, then the biggest values.
    setup(32'd300, 32'd0, 32'd0, 1'b0, 1'b1);
    send_req(OpRead, 31'd3, '0, OrgStart);
    setup(32'hffff_ffff, 32'h001f_ffff, 32'd15, 1'b0, 1'b1);
    send_req(OpSeek, '0, 32'hffff_0000, OrgEnd);
    send_req(OpRead, 31'h7fff_ffff, '0, OrgStart);

    // Receiver stalls a long time while requests keep coming.
    setup(32'd5000, 32'd8, 32'd4, 1'b0, 1'b1);
    hold_sink = 1'b1;
    for (int i = 0; i < 12; i++) send_req(OpRead, 31'($urandom_range(1, 60)), '0, OrgStart);

    // Random phases; mostly reads with some seeks.
    for (int ph = 0; ph < 4; ph++) begin
      logic [31:0] fs;
      fs = (ph == 3) ? $urandom : $urandom_range(0, 6000);
      setup(fs, (ph == 0) ? 1 : $urandom_range(1, 5000), $urandom_range(1, 8),
            ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) != 0));
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 2) == 0) rand_seek(fs);
        else rand_read();
      end
    end
    setup(32'd100000, 32'h0010_0000, 32'd8, 1'b0, 1'b0);
    setup(32'd100000, 32'd1024, 32'd8, 1'b0, 1'b1);
    for (int i = 0; i < 10; i++) rand_read();

    drain();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #200000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### segment_cache_read_splitter_top.f
rtl/scrs_pkg.sv
rtl/segment_cache_read_splitter_top.sv
rtl/scrs_checker.sv
test/segment_cache_read_splitter_checker.sv
test/tb_segment_cache_read_splitter_top.sv
